// File: rtl/tlr_pkg.sv
// shared constants, types and codes of the thick line rasterizer
package tlr_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COORD_W    = 12;
  localparam int PC_W       = COORD_W + 1;
  localparam int ERR_W      = COORD_W + 3;
  localparam int E2_W       = ERR_W + 1;
  localparam int RXY_W      = 8;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CMP_W      = COORD_W + 2;
  localparam int IN_DATA_W  = 4 * COORD_W + 2 * RXY_W;
  localparam int PIX_VAL_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam int WORD_BITS  = 16;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int PIXELS     = MAX_WIDTH * MAX_HEIGHT;
  localparam int PIX_W      = ($clog2(PIXELS) > BIT_W) ? $clog2(PIXELS) : BIT_W + 1;
  localparam int WADDR_W    = PIX_W - BIT_W;
  localparam int WORDS      = (PIXELS + WORD_BITS - 1) / WORD_BITS;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  localparam logic [PIX_VAL_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_VAL_W-1:0] PIX_BLACK = 8'd0;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PC_W-1:0]    pcoord_t;

  typedef struct packed {
    logic    vld;
    pcoord_t x;
    pcoord_t y;
  } pix_req_t;

endpackage

// File: rtl/tlr_line_stepper.sv
// bresenham sequencer: emits the main pixel and its neighbor for each step
module tlr_line_stepper (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tlr_pkg::coord_t   x0,
  input  tlr_pkg::coord_t   y0,
  input  tlr_pkg::coord_t   x1,
  input  tlr_pkg::coord_t   y1,
  output logic              busy,
  output tlr_pkg::pix_req_t pix
);
  import tlr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MAIN  = 3'b010,
    ST_NEIGH = 3'b100
  } st_t;

  st_t state_r, state_nxt;

  coord_t x_r, y_r, xe_r, ye_r;
  logic [COORD_W:0] dx_r, dy_r;
  logic sx_neg_r, sy_neg_r, steep_r;
  logic signed [ERR_W-1:0] err_r;

  pcoord_t ddx, ddy;
  logic [COORD_W:0] dx_abs, dy_abs;
  logic signed [E2_W-1:0] e2, dx_e, dy_e;
  logic step_x, step_y, at_end;
  logic signed [ERR_W-1:0] err_nxt;

  // setup from the endpoints of the accepted beat
  always_comb begin
    ddx    = {x1[COORD_W-1], x1} - {x0[COORD_W-1], x0};
    ddy    = {y1[COORD_W-1], y1} - {y0[COORD_W-1], y0};
    dx_abs = ddx[PC_W-1] ? $unsigned(-ddx) : $unsigned(ddx);
    dy_abs = ddy[PC_W-1] ? $unsigned(-ddy) : $unsigned(ddy);
  end

  always_comb begin
    e2      = {err_r, 1'b0};
    dx_e    = $signed(E2_W'(dx_r));
    dy_e    = $signed(E2_W'(dy_r));
    step_x  = e2 > -dy_e;
    step_y  = e2 < dx_e;
    at_end  = (x_r == xe_r) && (y_r == ye_r);
    err_nxt = err_r - (step_x ? $signed(ERR_W'(dy_r)) : '0)
                    + (step_y ? $signed(ERR_W'(dx_r)) : '0);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MAIN;
      ST_MAIN:  state_nxt = ST_NEIGH;
      ST_NEIGH: state_nxt = at_end ? ST_IDLE : ST_MAIN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      x_r      <= x0;
      y_r      <= y0;
      xe_r     <= x1;
      ye_r     <= y1;
      dx_r     <= dx_abs;
      dy_r     <= dy_abs;
      sx_neg_r <= !(x0 < x1);
      sy_neg_r <= !(y0 < y1);
      steep_r  <= dy_abs > dx_abs;
      err_r    <= $signed(ERR_W'(dx_abs)) - $signed(ERR_W'(dy_abs));
    end else if (state_r == ST_NEIGH && !at_end) begin
      err_r <= err_nxt;
      if (step_x) x_r <= sx_neg_r ? x_r - coord_t'(1) : x_r + coord_t'(1);
      if (step_y) y_r <= sy_neg_r ? y_r - coord_t'(1) : y_r + coord_t'(1);
    end
  end

  always_comb begin
    pix.vld = 1'b0;
    pix.x   = {x_r[COORD_W-1], x_r};
    pix.y   = {y_r[COORD_W-1], y_r};
    unique case (state_r)
      ST_MAIN: pix.vld = 1'b1;
      ST_NEIGH: begin
        pix.vld = 1'b1;
        if (steep_r) pix.x = {x_r[COORD_W-1], x_r} + pcoord_t'(1);
        else         pix.y = {y_r[COORD_W-1], y_r} + pcoord_t'(1);
      end
      default: pix.vld = 1'b0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: rtl/thick_line_rasterizer.sv
// top level: frame memory, read-modify-write pipeline, canvas registers and result beat
//
// After reset the block sweeps the frame memory to white, one 16-pixel word per cycle;
// in_tready stays low during the sweep (configuration writes are taken). A draw beat
// runs the line stepper, which issues one pixel access per cycle into the single
// read-modify-write path of the frame memory, two accesses per major-axis step; the next
// beat is taken the cycle after the last access. A read beat is issued once the output
// register is free, passes through the stage 2 register into the output register and
// always sees every earlier draw; a draw may be taken while a read result waits.
module thick_line_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // start_x, start_y, end_x, end_y, read_x, read_y
  input  logic [tlr_pkg::IN_DATA_W-1:0]      in_tdata,
  // opcode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pixel_value, in_canvas, zero fill
  output logic [tlr_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_we,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlr_pkg::CFG_W-1:0]          cfg_wdata
);
  import tlr_pkg::*;

  typedef enum logic [2:0] {
    T_CLEAR = 3'b001,
    T_IDLE  = 3'b010,
    T_READ  = 3'b100
  } top_st_t;

  top_st_t t_state_r, t_state_nxt;

  logic [CFG_W-1:0] canvas_w_r, canvas_h_r;
  logic [CMP_W-1:0] eff_w, eff_h;

  logic [WADDR_W-1:0] clr_cnt_r;
  logic clearing;

  logic [RXY_W-1:0] rx_r, ry_r;
  logic in_fire, step_start, step_busy, rd_issue;
  pix_req_t pix;

  // stage 1
  logic p_inc, rd_inc, s1_vld, s1_inc;
  logic [COORD_W-1:0] s1_ux, s1_uy;
  logic [PIX_W-1:0] s1_idx;

  // stage 2
  logic s2_vld_r, s2_rd_r, s2_inc_r;
  logic [WADDR_W-1:0] s2_addr_r;
  logic [BIT_W-1:0] s2_bit_r;
  logic [WORD_BITS-1:0] s2_word, s2_wdata;
  logic s2_we;

  logic fwd_vld_r;
  logic [WADDR_W-1:0] fwd_addr_r;
  logic [WORD_BITS-1:0] fwd_data_r;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] mem_rdata_r;
  logic mem_we;
  logic [WADDR_W-1:0] mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic out_valid_r, out_inc_r;
  logic [PIX_VAL_W-1:0] out_pix_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= CFG_W'(256);
      canvas_h_r <= CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_w_r <= cfg_wdata;
        REG_CANVAS_HEIGHT: canvas_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = (CMP_W'(canvas_w_r) > CMP_W'(MAX_WIDTH))  ? CMP_W'(MAX_WIDTH)  : CMP_W'(canvas_w_r);
    eff_h = (CMP_W'(canvas_h_r) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : CMP_W'(canvas_h_r);
  end

  // control
  assign clearing   = (t_state_r == T_CLEAR);
  assign in_tready  = (t_state_r == T_IDLE) && !step_busy;
  assign in_fire    = in_tvalid && in_tready;
  assign step_start = in_fire && (in_tuser == OP_DRAW);
  assign rd_issue   = (t_state_r == T_READ) && !out_valid_r;

  always_comb begin
    t_state_nxt = t_state_r;
    unique case (t_state_r)
      T_CLEAR: if (clr_cnt_r == WADDR_W'(WORDS - 1)) t_state_nxt = T_IDLE;
      T_IDLE:  if (in_fire && in_tuser == OP_READ) t_state_nxt = T_READ;
      T_READ:  if (!out_valid_r) t_state_nxt = T_IDLE;
      default: t_state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_state_r <= T_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      t_state_r <= t_state_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + WADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tuser == OP_READ) begin
      rx_r <= in_tdata[4*COORD_W +: RXY_W];
      ry_r <= in_tdata[4*COORD_W+RXY_W +: RXY_W];
    end
  end

  tlr_line_stepper u_stepper (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_start),
    .x0    (coord_t'(in_tdata[0*COORD_W +: COORD_W])),
    .y0    (coord_t'(in_tdata[1*COORD_W +: COORD_W])),
    .x1    (coord_t'(in_tdata[2*COORD_W +: COORD_W])),
    .y1    (coord_t'(in_tdata[3*COORD_W +: COORD_W])),
    .busy  (step_busy),
    .pix   (pix)
  );

  // stage 1: canvas check and word address
  always_comb begin
    p_inc  = !pix.x[PC_W-1] && !pix.y[PC_W-1]
             && (CMP_W'(pix.x[COORD_W-1:0]) < eff_w)
             && (CMP_W'(pix.y[COORD_W-1:0]) < eff_h);
    rd_inc = (CMP_W'(rx_r) < eff_w) && (CMP_W'(ry_r) < eff_h);
    s1_ux  = rd_issue ? COORD_W'(rx_r) : pix.x[COORD_W-1:0];
    s1_uy  = rd_issue ? COORD_W'(ry_r) : pix.y[COORD_W-1:0];
    s1_idx = PIX_W'(s1_uy) * PIX_W'(MAX_WIDTH) + PIX_W'(s1_ux);
    s1_vld = rd_issue || (pix.vld && p_inc);
    s1_inc = rd_issue ? rd_inc : p_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      s2_vld_r  <= s1_vld;
      fwd_vld_r <= s2_we;
    end
  end

  always_ff @(posedge clk) begin
    s2_rd_r    <= rd_issue;
    s2_inc_r   <= s1_inc;
    s2_addr_r  <= s1_idx[PIX_W-1:BIT_W];
    s2_bit_r   <= s1_idx[BIT_W-1:0];
    fwd_addr_r <= s2_addr_r;
    fwd_data_r <= s2_wdata;
  end

  // stage 2: the word written last cycle was read stale, take it from the bypass
  always_comb begin
    s2_word  = (fwd_vld_r && fwd_addr_r == s2_addr_r) ? fwd_data_r : mem_rdata_r;
    s2_wdata = s2_word & ~(WORD_BITS'(1) << s2_bit_r);
    s2_we    = s2_vld_r && !s2_rd_r;
  end

  always_comb begin
    mem_we    = clearing || s2_we;
    mem_waddr = clearing ? clr_cnt_r : s2_addr_r;
    mem_wdata = clearing ? '1 : s2_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[s1_idx[PIX_W-1:BIT_W]];
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_vld_r && s2_rd_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && s2_rd_r) begin
      out_inc_r <= s2_inc_r;
      out_pix_r <= (s2_inc_r && !s2_word[s2_bit_r]) ? PIX_BLACK : PIX_WHITE;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-PIX_VAL_W-1){1'b0}}, out_inc_r, out_pix_r};

  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("input beat offered during frame clear");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_rd_r) |-> !out_valid_r)
    else $error("read result overwrites a waiting beat");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_issue && pix.vld))
    else $error("read and line pixel issued together");

  a_write_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && !s2_rd_r) |-> s2_inc_r)
    else $error("frame write outside canvas");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == OP_READ) |=> (t_state_r == T_READ))
    else $error("accepted read beat not pending");

endmodule

// File: test/tb.sv
// self-checking thick line rasterizer testbench: directed and random stream traffic against a pixel predictor
`timescale 1ns / 1ps

module tb;
  import tlr_pkg::*;

  localparam int LINE_DRAIN = 2 * 4096 + 64;
  localparam int PHASES     = 10;
  localparam int PHASE_ITEMS = 45;

  typedef struct packed {
    logic [PIX_VAL_W-1:0] pixel_value;
    logic                 in_canvas;
  } pixel_read_t;

  class pixel_scoreboard;
    bit          frame [0:PIXELS-1];
    int          width_reg;
    int          height_reg;
    pixel_read_t pending_reads [$];
    int          errors;

    function new();
      foreach (frame[i]) frame[i] = 1'b1;
      width_reg  = 256;
      height_reg = 256;
      errors     = 0;
    endfunction

    function int eff_w();
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function int eff_h();
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function void set_canvas(int w, int h);
      width_reg  = w;
      height_reg = h;
    endfunction

    function void blacken(int x, int y);
      if (x < 0 || y < 0 || x >= eff_w() || y >= eff_h()) return;
      frame[y * MAX_WIDTH + x] = 1'b0;
    endfunction

    function void trace_line(int x, int y, int xe, int ye);
      int dx, dy, sx, sy, err, e2;
      bit steep;
      dx    = (xe > x) ? xe - x : x - xe;
      dy    = (ye > y) ? ye - y : y - ye;
      sx    = (x < xe) ? 1 : -1;
      sy    = (y < ye) ? 1 : -1;
      steep = dy > dx;
      err   = dx - dy;
      forever begin
        blacken(x, y);
        // second pixel goes across the minor axis
        if (steep) blacken(x + 1, y);
        else blacken(x, y + 1);
        if (x == xe && y == ye) break;
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x   += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y   += sy;
        end
      end
    endfunction

    function void take_beat(logic op, logic [IN_DATA_W-1:0] beat);
      int rx, ry;
      pixel_read_t res;
      if (op == OP_DRAW) begin
        trace_line(int'($signed(beat[11:0])), int'($signed(beat[23:12])),
                   int'($signed(beat[35:24])), int'($signed(beat[47:36])));
        return;
      end
      rx = int'(beat[55:48]);
      ry = int'(beat[63:56]);
      if (rx >= eff_w() || ry >= eff_h()) begin
        res.pixel_value = PIX_WHITE;
        res.in_canvas   = 1'b0;
      end else begin
        res.pixel_value = frame[ry * MAX_WIDTH + rx] ? PIX_WHITE : PIX_BLACK;
        res.in_canvas   = 1'b1;
      end
      pending_reads.push_back(res);
    endfunction

    function void check_pixel(logic [OUT_DATA_W-1:0] beat);
      pixel_read_t exp_read;
      if (pending_reads.size() == 0) begin
        $error("result beat 0x%h with no read pending", beat);
        errors++;
        return;
      end
      exp_read = pending_reads.pop_front();
      if (beat[7:0] !== exp_read.pixel_value) begin
        $error("pixel_value mismatch: expected %0d, actual %0d", exp_read.pixel_value, beat[7:0]);
        errors++;
      end
      if (beat[8] !== exp_read.in_canvas) begin
        $error("in_canvas mismatch: expected %0d, actual %0d", exp_read.in_canvas, beat[8]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  pixel_scoreboard sb;
  int in_calm;
  int out_calm;
  int line_x0, line_y0, line_x1, line_y1;

  thick_line_rasterizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    sb      = new();
    in_calm  = 0;
    out_calm = 0;
  end

  // gap before the next beat; now and then a run of back-to-back beats
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 14);
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp_byte(int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(int sx, int sy, int ex, int ey,
                                                     int rx, int ry);
    return {8'(ry), 8'(rx), 12'(ey), 12'(ex), 12'(sy), 12'(sx)};
  endfunction

  // mostly lines around the canvas, some short, a few over the whole coordinate range
  function automatic logic [IN_DATA_W-1:0] random_line();
    int w, h, k;
    w = sb.eff_w();
    h = sb.eff_h();
    k = $urandom_range(0, 99);
    if (k < 6) return {$urandom, $urandom};
    line_x0 = rand_between(-8, w + 8);
    line_y0 = rand_between(-8, h + 8);
    if (k < 40) begin
      line_x1 = line_x0 + rand_between(-12, 12);
      line_y1 = line_y0 + rand_between(-12, 12);
    end else begin
      line_x1 = rand_between(-8, w + 8);
      line_y1 = rand_between(-8, h + 8);
    end
    return pack_item(line_x0, line_y0, line_x1, line_y1,
                     $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // reads land near the last line endpoints often enough to find black pixels
  function automatic logic [IN_DATA_W-1:0] random_read();
    logic [IN_DATA_W-1:0] beat;
    int rx, ry;
    beat = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 55) begin
      if ($urandom_range(0, 1) == 0) begin
        rx = line_x0;
        ry = line_y0;
      end else begin
        rx = line_x1;
        ry = line_y1;
      end
      beat[55:48] = 8'(clamp_byte(rx + rand_between(-1, 1)));
      beat[63:56] = 8'(clamp_byte(ry + rand_between(-1, 1)));
    end
    return beat;
  endfunction

  task automatic send_beat(input logic op, input logic [IN_DATA_W-1:0] beat);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_canvas(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CANVAS_WIDTH;
    cfg_wdata <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= REG_CANVAS_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_canvas(w, h);
  endtask

  // hold off input until every read is answered and the last line has finished
  task automatic settle();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (sb.pending_reads.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LINE_DRAIN) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.take_beat(in_tuser, in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata);
  end

  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_gap(out_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int plan_w [PHASES];
    int plan_h [PHASES];
    plan_w = '{256, 1, 511, 0, 100, 256, 1, 300, 0, 257};
    plan_h = '{256, 1, 511, 0, 37, 1, 256, 200, 0, 256};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_DRAW;
    cfg_we    <= 1'b0;
    cfg_index <= REG_CANVAS_WIDTH;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on the reset canvas
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 0, 0));
    send_beat(OP_READ, pack_item(-1, -1, -1, -1, 255, 255));
    send_beat(OP_DRAW, pack_item(0, 0, 10, 0, 255, 255));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 10, 1));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 11, 0));
    send_beat(OP_DRAW, pack_item(5, 20, 7, 40, 0, 0));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 8, 40));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 6, 30));
    send_beat(OP_DRAW, pack_item(100, 100, 100, 100, 0, 0));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 100, 101));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 101, 100));
    send_beat(OP_DRAW, pack_item(-2048, -2048, 2047, 2047, 0, 0));
    send_beat(OP_DRAW, pack_item(2047, -2048, -2048, 2047, 0, 0));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 128, 128));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 128, 129));
    send_beat(OP_DRAW, pack_item(300, 300, 400, 500, 0, 0));
    // lines on the right and bottom edges lose their neighbor pixel
    send_beat(OP_DRAW, pack_item(255, 0, 255, 10, 0, 0));
    send_beat(OP_DRAW, pack_item(0, 255, 20, 255, 0, 0));
    send_beat(OP_DRAW, pack_item(200, 50, 190, 45, 0, 0));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 255, 5));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 10, 255));
    send_beat(OP_READ, pack_item(0, 0, 0, 0, 195, 47));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 8) write_canvas($urandom_range(0, 511), $urandom_range(0, 511));
      else write_canvas(plan_w[p], plan_h[p]);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 45) send_beat(OP_READ, random_read());
        else send_beat(OP_DRAW, random_line());
      end
      settle();
    end

    if (sb.pending_reads.size() != 0) begin
      $error("%0d reads never answered", sb.pending_reads.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: thick_line_rasterizer.f
rtl/tlr_pkg.sv
rtl/tlr_line_stepper.sv
rtl/thick_line_rasterizer.sv
test/tb.sv
